// ===== design/halo_lattice_site_index_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lattice site index block
// Concurrent checks clocked by clock, with or without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef HALO_LATTICE_SITE_INDEX_MACROS_SVH
`define HALO_LATTICE_SITE_INDEX_MACROS_SVH
`ifndef SYNTHESIS
`define HLSI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define HLSI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define HLSI_ASSERT(lbl, prop, msg)
`define HLSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/hlsi_pkg.sv =====
// ---------------------------------------------------------------------------
// Lattice site index package
// Shared codes and the control record that travels down the pipeline.
// ---------------------------------------------------------------------------
package hlsi_pkg;

   localparam int IDX_W   = 31;
   localparam int COORD_W = 12;
   localparam int EXT_W   = 11;
   localparam int HALO_W  = 4;
   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   typedef enum logic [1:0] {
      REG_EXTENT_X,
      REG_EXTENT_Y,
      REG_EXTENT_Z,
      REG_HALO_WIDTH
   } reg_index_type;

   typedef enum logic {
      MODE_TO_INDEX,
      MODE_TO_COORD
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     flag;
   } ctl_type;

   localparam ctl_type CTL_IDLE = '{valid: 1'b0, mode: MODE_TO_INDEX, flag: 1'b0};

endpackage

// ===== design/hlsi_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one conversion request.
// ---------------------------------------------------------------------------
interface hlsi_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [11:0] coord_x;
   logic [11:0] coord_y;
   logic [11:0] coord_z;
   logic [30:0] site_index;

   modport source (output valid, mode, coord_x, coord_y, coord_z, site_index,
                   input ready);
   modport sink (input valid, mode, coord_x, coord_y, coord_z, site_index,
                 output ready);
endinterface

// ===== design/hlsi_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one conversion result.
// ---------------------------------------------------------------------------
interface hlsi_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] index_out;
   logic [11:0] x_out;
   logic [11:0] y_out;
   logic [11:0] z_out;
   logic        out_of_range;

   modport source (output valid, index_out, x_out, y_out, z_out, out_of_range,
                   input ready);
   modport sink (input valid, index_out, x_out, y_out, z_out, out_of_range,
                 output ready);
endinterface

// ===== design/hlsi_cell.sv =====
// ---------------------------------------------------------------------------
// Division cell
// One restoring step: subtracts the shifted stride when it fits and sets
// one quotient bit, then hands the record to the next cell.
// ---------------------------------------------------------------------------
module hlsi_cell #(
   parameter int PW  = 11,
   parameter int BIT = 0,
   parameter int POS = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [2*PW-1:0]          divisor,
   input  hlsi_pkg::ctl_type        ctl_i,
   input  logic [hlsi_pkg::IDX_W-1:0] rem_i,
   input  logic [2*PW-1:0]          quot_i,
   input  logic [hlsi_pkg::IDX_W-1:0] res_i,
   output hlsi_pkg::ctl_type        ctl_o,
   output logic [hlsi_pkg::IDX_W-1:0] rem_o,
   output logic [2*PW-1:0]          quot_o,
   output logic [hlsi_pkg::IDX_W-1:0] res_o
);
   import hlsi_pkg::*;

   localparam int CW = (3*PW+1 > IDX_W+1) ? 3*PW+1 : IDX_W+1;

   ctl_type          ctl_ff;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [2*PW-1:0]  quot_ff, quot_in;
   logic [IDX_W-1:0] res_ff;
   logic [CW-1:0]    wide_div;
   logic             take;

   always_comb begin
      wide_div = CW'(divisor) << BIT;
      take     = (ctl_i.mode == MODE_TO_COORD) && (CW'(rem_i) >= wide_div);
      rem_in   = take ? (rem_i - wide_div[IDX_W-1:0]) : rem_i;
      quot_in  = quot_i;
      quot_in[POS] = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= CTL_IDLE;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         res_ff  <= res_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;
   assign res_o  = res_ff;

endmodule

// ===== design/hlsi_front.sv =====
// ---------------------------------------------------------------------------
// Front end
// Range check and halo offsets, then the index multiply-add for the
// coordinate-to-index direction, over three registered stages.
// ---------------------------------------------------------------------------
module hlsi_front #(
   parameter int PW = 11,
   parameter int HW = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  hlsi_pkg::ctl_type            ctl_i,
   input  logic [hlsi_pkg::COORD_W-1:0] coord_x,
   input  logic [hlsi_pkg::COORD_W-1:0] coord_y,
   input  logic [hlsi_pkg::COORD_W-1:0] coord_z,
   input  logic [hlsi_pkg::IDX_W-1:0]   site_index,
   input  logic [HW-1:0]                halo,
   input  logic [PW-1:0]                px,
   input  logic [PW-1:0]                py,
   input  logic [PW-1:0]                pz,
   input  logic [2*PW-1:0]              sx,
   input  logic [3*PW-1:0]              nsites,
   output hlsi_pkg::ctl_type            ctl_o,
   output logic [hlsi_pkg::IDX_W-1:0]   rem_o,
   output logic [hlsi_pkg::IDX_W-1:0]   res_o
);
   import hlsi_pkg::*;

   localparam int OW = (PW+2 > COORD_W+2) ? PW+2 : COORD_W+2;
   localparam int CW = (3*PW+1 > IDX_W+1) ? 3*PW+1 : IDX_W+1;

   logic signed [OW-1:0] off_x, off_y, off_z, hoff;
   logic                 bad_coord, bad_index;
   ctl_type              ctl_a_ff, ctl_a_in, ctl_b_ff, ctl_c_ff;
   logic [PW-1:0]        ox_a_ff, oy_a_ff, oz_a_ff;
   logic [IDX_W-1:0]     idx_a_ff, idx_b_ff, idx_c_ff;
   logic [3*PW-1:0]      pa_b_ff;
   logic [2*PW:0]        pb_b_ff;
   logic [CW-1:0]        sum_c;
   logic [IDX_W-1:0]     res_c_ff;

   always_comb begin
      hoff  = $signed(OW'(halo)) - $signed(OW'(1));
      off_x = $signed({{(OW-COORD_W){coord_x[COORD_W-1]}}, coord_x}) + hoff;
      off_y = $signed({{(OW-COORD_W){coord_y[COORD_W-1]}}, coord_y}) + hoff;
      off_z = $signed({{(OW-COORD_W){coord_z[COORD_W-1]}}, coord_z}) + hoff;
      bad_coord = off_x[OW-1] || off_y[OW-1] || off_z[OW-1] ||
                  (off_x >= $signed(OW'(px))) || (off_y >= $signed(OW'(py))) ||
                  (off_z >= $signed(OW'(pz)));
      bad_index = CW'(site_index) >= CW'(nsites);
      ctl_a_in      = ctl_i;
      ctl_a_in.flag = (ctl_i.mode == MODE_TO_COORD) ? bad_index : bad_coord;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= CTL_IDLE;
         ctl_b_ff <= CTL_IDLE;
         ctl_c_ff <= CTL_IDLE;
      end else if (advance) begin
         ctl_a_ff <= ctl_a_in;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   assign sum_c = CW'(pa_b_ff) + CW'(pb_b_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         ox_a_ff  <= off_x[PW-1:0];
         oy_a_ff  <= off_y[PW-1:0];
         oz_a_ff  <= off_z[PW-1:0];
         idx_a_ff <= site_index;
         pa_b_ff  <= (3*PW)'(ox_a_ff) * (3*PW)'(sx);
         pb_b_ff  <= (2*PW+1)'(oy_a_ff) * (2*PW+1)'(pz) + (2*PW+1)'(oz_a_ff);
         idx_b_ff <= idx_a_ff;
         res_c_ff <= sum_c[IDX_W-1:0];
         idx_c_ff <= idx_b_ff;
      end
   end

   assign ctl_o = ctl_c_ff;
   assign rem_o = idx_c_ff;
   assign res_o = res_c_ff;

endmodule

// ===== design/halo_lattice_site_index.sv =====
// ---------------------------------------------------------------------------
// Lattice site index with halo
// Converts between halo-padded 3D lattice coordinates and a linear index.
// ---------------------------------------------------------------------------
// One request is taken per clock while the response side is not stalled and no
// register write is settling. PW is the width of a padded axis length. The chain
// is three front stages, one restoring division cell per quotient bit for x and
// for y, and the output register. A stalled response freezes the whole chain.
// After a register write, request ready stays low while the strides and the
// site count are recomputed through two multiplier stages.
module halo_lattice_site_index #(
   parameter int MAX_EXTENT = 1024,
   parameter int MAX_HALO   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  hlsi_pkg::reg_index_type       csr_index,
   input  logic [hlsi_pkg::EXT_W-1:0]    csr_wdata,
   hlsi_req_if.sink                      req_chan,
   hlsi_rsp_if.source                    rsp_chan
);
   import hlsi_pkg::*;
   `include "halo_lattice_site_index_macros.svh"

   localparam int PW = $clog2(MAX_EXTENT + 2*MAX_HALO + 1);
   localparam int HW = $clog2(MAX_HALO + 1);
   localparam int OW = (PW+2 > COORD_W+2) ? PW+2 : COORD_W+2;
   localparam int NC = 2*PW;

   logic [EXT_W-1:0]    ext_x_ff, ext_y_ff, ext_z_ff;
   logic [HALO_W-1:0]   halo_ff;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [PW-1:0]       nx, ny, nz;
   logic [HW-1:0]       hc;
   logic [HW-1:0]       h_ff;
   logic [PW-1:0]       px_ff, py_ff, pz_ff;
   logic [2*PW-1:0]     sxa_ff, sx_ff;
   logic [3*PW-1:0]     ns_ff;
   logic                advance, out_valid_ff;
   ctl_type             in_ctl;
   ctl_type             out_ctl_ff;
   logic [IDX_W-1:0]    out_index_ff;
   logic [COORD_W-1:0]  out_x_ff, out_y_ff, out_z_ff;
   logic                out_coords_zero, out_all_zero;

   ctl_type          ctl_c [0:NC];
   logic [IDX_W-1:0] rem_c [0:NC];
   logic [2*PW-1:0]  quot_c [0:NC];
   logic [IDX_W-1:0] res_c [0:NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff <= EXT_W'(64);
         ext_y_ff <= EXT_W'(64);
         ext_z_ff <= EXT_W'(64);
         halo_ff  <= HALO_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_EXTENT_X:   ext_x_ff <= csr_wdata;
            REG_EXTENT_Y:   ext_y_ff <= csr_wdata;
            REG_EXTENT_Z:   ext_z_ff <= csr_wdata;
            REG_HALO_WIDTH: halo_ff  <= csr_wdata[HALO_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [PW-1:0] clamp_ext(input logic [EXT_W-1:0] v);
      logic [PW-1:0] r;
      if (v == '0) r = PW'(1);
      else if (32'(v) > MAX_EXTENT) r = PW'(MAX_EXTENT);
      else r = PW'(v);
      return r;
   endfunction

   always_comb begin
      nx = clamp_ext(ext_x_ff);
      ny = clamp_ext(ext_y_ff);
      nz = clamp_ext(ext_z_ff);
      if (halo_ff == '0) hc = HW'(1);
      else if (32'(halo_ff) > MAX_HALO) hc = HW'(MAX_HALO);
      else hc = HW'(halo_ff);
   end

   always_ff @(posedge clock) begin
      h_ff   <= hc;
      px_ff  <= nx + (PW'(hc) << 1);
      py_ff  <= ny + (PW'(hc) << 1);
      pz_ff  <= nz + (PW'(hc) << 1);
      sxa_ff <= (2*PW)'(ny + (PW'(hc) << 1)) * (2*PW)'(nz + (PW'(hc) << 1));
      sx_ff  <= sxa_ff;
      ns_ff  <= (3*PW)'(sxa_ff) * (3*PW)'(px_ff);
   end

   always_comb begin
      settle_in = settle_ff;
      if (csr_we) settle_in = SETTLE_CYCLES;
      else if (settle_ff != '0) settle_in = settle_ff - SETTLE_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) settle_ff <= SETTLE_CYCLES;
      else settle_ff <= settle_in;
   end

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance && (settle_ff == '0);

   always_comb begin
      in_ctl.valid = req_chan.valid && req_chan.ready;
      in_ctl.mode  = mode_type'(req_chan.mode);
      in_ctl.flag  = 1'b0;
   end

   hlsi_front #(.PW(PW), .HW(HW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctl_i      (in_ctl),
      .coord_x    (req_chan.coord_x),
      .coord_y    (req_chan.coord_y),
      .coord_z    (req_chan.coord_z),
      .site_index (req_chan.site_index),
      .halo       (h_ff),
      .px         (px_ff),
      .py         (py_ff),
      .pz         (pz_ff),
      .sx         (sx_ff),
      .nsites     (ns_ff),
      .ctl_o      (ctl_c[0]),
      .rem_o      (rem_c[0]),
      .res_o      (res_c[0])
   );

   assign quot_c[0] = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      localparam int BIT = (i < PW) ? PW-1-i : 2*PW-1-i;
      logic [2*PW-1:0] div;
      assign div = (i < PW) ? sx_ff : (2*PW)'(pz_ff);
      hlsi_cell #(.PW(PW), .BIT(BIT), .POS(2*PW-1-i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .divisor (div),
         .ctl_i   (ctl_c[i]),
         .rem_i   (rem_c[i]),
         .quot_i  (quot_c[i]),
         .res_i   (res_c[i]),
         .ctl_o   (ctl_c[i+1]),
         .rem_o   (rem_c[i+1]),
         .quot_o  (quot_c[i+1]),
         .res_o   (res_c[i+1])
      );
   end

   logic          coord_ok;
   logic [OW-1:0] cx, cy, cz;

   always_comb begin
      coord_ok = (ctl_c[NC].mode == MODE_TO_COORD) && !ctl_c[NC].flag;
      cx = OW'(quot_c[NC][2*PW-1:PW]) - OW'(h_ff) + OW'(1);
      cy = OW'(quot_c[NC][PW-1:0]) - OW'(h_ff) + OW'(1);
      cz = OW'(rem_c[NC][PW-1:0]) - OW'(h_ff) + OW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_ctl_ff   <= CTL_IDLE;
      end else if (advance) begin
         out_valid_ff <= ctl_c[NC].valid;
         out_ctl_ff   <= ctl_c[NC];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_index_ff <= (ctl_c[NC].mode == MODE_TO_INDEX && !ctl_c[NC].flag) ?
                         res_c[NC] : '0;
         out_x_ff <= coord_ok ? cx[COORD_W-1:0] : '0;
         out_y_ff <= coord_ok ? cy[COORD_W-1:0] : '0;
         out_z_ff <= coord_ok ? cz[COORD_W-1:0] : '0;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.index_out    = out_index_ff;
   assign rsp_chan.x_out        = out_x_ff;
   assign rsp_chan.y_out        = out_y_ff;
   assign rsp_chan.z_out        = out_z_ff;
   assign rsp_chan.out_of_range = out_ctl_ff.flag;

   assign out_coords_zero = (out_x_ff == '0) && (out_y_ff == '0) && (out_z_ff == '0);
   assign out_all_zero    = out_coords_zero && (out_index_ff == '0);

   `HLSI_ASSERT(a_flag_zero, out_valid_ff && out_ctl_ff.flag |-> out_all_zero, "flag fields")
   `HLSI_ASSERT(a_index_mode, out_valid_ff && out_ctl_ff.mode == MODE_TO_INDEX |-> out_coords_zero, "coords")
   `HLSI_ASSERT(a_write_blocks, csr_we |=> !req_chan.ready, "request taken right after a write")
   `HLSI_ASSERT_ALWAYS(a_settled, req_chan.valid && req_chan.ready |-> settle_ff == '0, "unsettled")

endmodule

// ===== tb/tb_halo_lattice_site_index.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lattice site index testbench
// Drives coordinate-to-index and index-to-coordinate requests through the
// block under several lattice and halo settings, predicts every result from
// the current settings and compares each response transfer field by field.
// ---------------------------------------------------------------------------
module tb_halo_lattice_site_index;
   import hlsi_pkg::*;

   typedef struct {
      mode_type    mode;
      logic [11:0] cx;
      logic [11:0] cy;
      logic [11:0] cz;
      logic [30:0] sidx;
   } site_request_type;

   typedef struct {
      logic [30:0] index;
      logic [11:0] x;
      logic [11:0] y;
      logic [11:0] z;
      logic        flag;
   } site_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   reg_index_type csr_index = REG_EXTENT_X;
   logic [EXT_W-1:0] csr_wdata = '0;

   hlsi_req_if req_bus ();
   hlsi_rsp_if rsp_bus ();

   halo_lattice_site_index u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   logic [EXT_W-1:0]  lat_extent [3];
   logic [HALO_W-1:0] lat_halo;
   site_result_type   site_expect_q [$];
   bit                steady = 1'b0;
   int                errors = 0;
   int                n_to_index = 0;
   int                n_to_coord = 0;
   int                n_flagged = 0;
   int                n_settings = 0;

   always #2 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.coord_z = '0;
      req_bus.site_index = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic void lattice_sizes(output longint nx, ny, nz, h);
      longint e [3];
      for (int a = 0; a < 3; a++) begin
         e[a] = longint'(lat_extent[a]);
         if (e[a] < 1) e[a] = 1;
         if (e[a] > 1024) e[a] = 1024;
      end
      nx = e[0];
      ny = e[1];
      nz = e[2];
      h = longint'(lat_halo);
      if (h < 1) h = 1;
      if (h > 8) h = 8;
   endfunction

   function automatic longint site_count();
      longint nx, ny, nz, h;
      lattice_sizes(nx, ny, nz, h);
      return (nx + 2 * h) * (ny + 2 * h) * (nz + 2 * h);
   endfunction

   function automatic site_result_type predict_site(site_request_type r);
      site_result_type res;
      longint nx, ny, nz, h, lo, sy, sx, ns, x, y, z, idx, rem, q;
      lattice_sizes(nx, ny, nz, h);
      lo = 1 - h;
      sy = nz + 2 * h;
      sx = sy * (ny + 2 * h);
      ns = sx * (nx + 2 * h);
      res = '{index: '0, x: '0, y: '0, z: '0, flag: 1'b0};
      if (r.mode == MODE_TO_INDEX) begin
         x = longint'($signed(r.cx));
         y = longint'($signed(r.cy));
         z = longint'($signed(r.cz));
         if (x < lo || y < lo || z < lo || x > nx + h || y > ny + h || z > nz + h) begin
            res.flag = 1'b1;
         end else begin
            idx = (x - lo) * sx + (y - lo) * sy + (z - lo);
            res.index = idx[30:0];
         end
      end else begin
         idx = longint'(r.sidx);
         if (idx >= ns) begin
            res.flag = 1'b1;
         end else begin
            rem = idx % sx;
            q = lo + idx / sx;
            res.x = q[11:0];
            q = lo + rem / sy;
            res.y = q[11:0];
            q = lo + rem % sy;
            res.z = q[11:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      site_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (site_expect_q.size() == 0) begin
               $display("%0t: response transfer with no request outstanding", $time);
               errors++;
            end else begin
               want = site_expect_q.pop_front();
               if (rsp_bus.index_out !== want.index) begin
                  $display("%0t: index_out expected %0d actual %0d", $time, want.index,
                           rsp_bus.index_out);
                  errors++;
               end
               if (rsp_bus.x_out !== want.x) begin
                  $display("%0t: x_out expected %h actual %h", $time, want.x, rsp_bus.x_out);
                  errors++;
               end
               if (rsp_bus.y_out !== want.y) begin
                  $display("%0t: y_out expected %h actual %h", $time, want.y, rsp_bus.y_out);
                  errors++;
               end
               if (rsp_bus.z_out !== want.z) begin
                  $display("%0t: z_out expected %h actual %h", $time, want.z, rsp_bus.z_out);
                  errors++;
               end
               if (rsp_bus.out_of_range !== want.flag) begin
                  $display("%0t: out_of_range expected %b actual %b", $time, want.flag,
                           rsp_bus.out_of_range);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 26);
      end
   end

   task automatic send_request(site_request_type r);
      if (!steady) begin
         while ($urandom_range(0, 99) < 26) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= r.mode;
      req_bus.coord_x <= r.cx;
      req_bus.coord_y <= r.cy;
      req_bus.coord_z <= r.cz;
      req_bus.site_index <= r.sidx;
      do @(posedge clock); while (!req_bus.ready);
      site_expect_q.push_back(predict_site(r));
      if (r.mode == MODE_TO_INDEX) n_to_index++;
      else n_to_coord++;
      if (site_expect_q[$].flag) n_flagged++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (site_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_lattice(logic [EXT_W-1:0] ex, ey, ez, logic [EXT_W-1:0] hw);
      logic [EXT_W-1:0] vals [4];
      reg_index_type ri [4];
      vals = '{ex, ey, ez, hw};
      ri = '{REG_EXTENT_X, REG_EXTENT_Y, REG_EXTENT_Z, REG_HALO_WIDTH};
      drain_results();
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= ri[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         if (i < 3) lat_extent[i] = vals[i];
         else lat_halo = vals[i][HALO_W-1:0];
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   function automatic site_request_type random_request();
      site_request_type r;
      longint nx, ny, nz, h, ns, v;
      int pick;
      lattice_sizes(nx, ny, nz, h);
      ns = site_count();
      pick = $urandom_range(0, 9);
      r.mode = mode_type'($urandom_range(0, 1));
      r.cx = 12'($urandom);
      r.cy = 12'($urandom);
      r.cz = 12'($urandom);
      r.sidx = 31'($urandom);
      if (r.mode == MODE_TO_INDEX) begin
         if (pick < 9) begin
            v = $urandom_range(0, nx + 2 * h - 1) + 1 - h;
            r.cx = v[11:0];
            v = $urandom_range(0, ny + 2 * h - 1) + 1 - h;
            r.cy = v[11:0];
            v = $urandom_range(0, nz + 2 * h - 1) + 1 - h;
            r.cz = v[11:0];
         end
         if (pick == 8) begin
            case ($urandom_range(0, 2))
               0: begin v = ($urandom_range(0, 1) ? -h : nx + h + 1); r.cx = v[11:0]; end
               1: begin v = ($urandom_range(0, 1) ? -h : ny + h + 1); r.cy = v[11:0]; end
               default: begin v = ($urandom_range(0, 1) ? -h : nz + h + 1); r.cz = v[11:0]; end
            endcase
         end
      end else begin
         if (pick < 8) begin
            v = $urandom_range(0, ns - 1);
            r.sidx = v[30:0];
         end else if (pick == 8) begin
            v = ns + $urandom_range(0, 3);
            r.sidx = v[30:0];
         end
      end
      return r;
   endfunction

   task automatic send_corners();
      longint nx, ny, nz, h, ns;
      logic [11:0] lo, hx, hy, hz;
      site_request_type c [$];
      lattice_sizes(nx, ny, nz, h);
      ns = site_count();
      lo = 12'(1 - h);
      hx = 12'(nx + h);
      hy = 12'(ny + h);
      hz = 12'(nz + h);
      c.push_back('{MODE_TO_INDEX, lo, lo, lo, '0});
      c.push_back('{MODE_TO_INDEX, hx, hy, hz, 31'h7FFF_FFFF});
      c.push_back('{MODE_TO_INDEX, lo - 12'd1, lo, lo, '0});
      c.push_back('{MODE_TO_INDEX, lo, hy + 12'd1, lo, '0});
      c.push_back('{MODE_TO_INDEX, lo, lo, hz + 12'd1, '0});
      c.push_back('{MODE_TO_INDEX, 12'h800, 12'h7FF, 12'h001, '0});
      c.push_back('{MODE_TO_COORD, 12'hFFF, 12'hFFF, 12'hFFF, '0});
      c.push_back('{MODE_TO_COORD, '0, '0, '0, 31'(ns - 1)});
      c.push_back('{MODE_TO_COORD, '0, '0, '0, 31'(ns)});
      c.push_back('{MODE_TO_COORD, '0, '0, '0, 31'h7FFF_FFFF});
      c.push_back('{MODE_TO_COORD, '0, '0, '0, 31'(nz + 2 * h)});
      foreach (c[i]) send_request(c[i]);
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 49) == 0) drain_results();
         send_request(random_request());
      end
   endtask

   task automatic test_reset_lattice();
      lat_extent = '{11'd64, 11'd64, 11'd64};
      lat_halo = 4'd1;
      send_corners();
      send_random(30);
   endtask

   task automatic test_extreme_lattices();
      write_lattice(11'd1, 11'd1, 11'd1, 11'd1);
      send_corners();
      write_lattice(11'd1024, 11'd1024, 11'd1024, 11'd8);
      send_random(30);
      write_lattice(11'd0, 11'd2047, 11'd1025, 11'h7F0);
      send_random(30);
      write_lattice(11'd2047, 11'd0, 11'd3, 11'd15);
      send_random(30);
   endtask

   task automatic test_random_lattices();
      logic [EXT_W-1:0] e [3];
      for (int k = 0; k < 6; k++) begin
         for (int a = 0; a < 3; a++)
            e[a] = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 40));
         write_lattice(e[0], e[1], e[2], 11'($urandom));
         send_random(40);
      end
   endtask

   task automatic test_back_to_back();
      write_lattice(11'd5, 11'd300, 11'd17, 11'd4);
      steady = 1'b1;
      send_random(120);
      drain_results();
      steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_lattice();
      test_extreme_lattices();
      test_random_lattices();
      test_back_to_back();
      drain_results();
      repeat (40) @(posedge clock);
      $display("Covered %0d lattice settings: %0d coordinate and %0d index requests.",
               n_settings, n_to_index, n_to_coord);
      $display("Of these, %0d were outside the padded lattice.", n_flagged);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Timeout waiting for transfers.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
